/* design/depth_pixel_to_world_point_core_assert.svh */
// Assertion macros for the back-projection core.
// Both macros assume a clock named clock and a reset named reset in scope.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH

// Same-cycle implication.
`define DPW_ASSERT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DPW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dpw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dpw_pkg;

   // Frame limits and store layout.
   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;
   localparam int unsigned K_WORDS    = 9;
   localparam int unsigned POSE_BASE  = 9;
   localparam int unsigned POSE_WORDS = 16;

   // Column and row limits, 17 bits wide, wider than the largest frame dimension.
   localparam int unsigned FRAME_W = 17;
   localparam logic [FRAME_W-1:0] COL_LIMIT = FRAME_W'(MAX_WIDTH);
   localparam logic [FRAME_W-1:0] ROW_LIMIT = FRAME_W'(MAX_HEIGHT);

   // Width of the shifted dividend and of the divisor magnitude.
   localparam int unsigned DVD_W = 48;
   localparam int unsigned DSR_W = 32;

   // Register reset values.
   localparam logic [31:0] DEPTH_SCALE_RST = 32'd65;
   localparam logic [30:0] MIN_DEPTH_RST   = 31'd0;
   localparam logic [30:0] MAX_DEPTH_RST   = 31'd655360;

   typedef enum logic [1:0] {
      CSR_DEPTH_SCALE = 2'd0,
      CSR_MIN_DEPTH   = 2'd1,
      CSR_MAX_DEPTH   = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_LOAD  = 1'b1
   } action_type;

   typedef struct packed {
      logic               action;
      logic [4:0]         coef_index;
      logic signed [31:0] coef_value;
      logic [11:0]        col;
      logic [11:0]        row;
      logic [15:0]        raw_depth;
   } req_type;

   typedef struct packed {
      logic               point_valid;
      logic               arith_fault;
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } rsp_type;

   typedef struct packed {
      logic [31:0] depth_scale;
      logic [30:0] min_depth_m;
      logic [30:0] max_depth_m;
   } cfg_type;

   // A coefficient load traveling with its request.
   typedef struct packed {
      logic        en;
      logic [4:0]  index;
      logic [31:0] value;
   } load_type;

   // Status that travels with a pixel request.
   typedef struct packed {
      logic ok;
      logic locz0;
      logic fault;
   } flag_type;

   // Sideband through the scale divider.
   typedef struct packed {
      flag_type          flags;
      load_type          load;
      logic [2:0][31:0]  loc;
   } sc_tag_type;

   // Sideband through the world divider.
   typedef struct packed {
      flag_type          flags;
      logic              h3zero;
      logic [2:0][31:0]  cam;
   } wd_tag_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } sat_type;

   // Saturate a wide signed value to 32 bits and report clipping.
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v[63:31] == {33{v[63]}}) begin
         r.val = v[31:0];
         r.sat = 1'b0;
      end else begin
         r.val = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         r.sat = 1'b1;
      end
      return r;
   endfunction

   // Magnitude of a signed word as an unsigned word.
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   // Apply the quotient sign and saturate.
   function automatic sat_type div_result(input logic [DVD_W-1:0] mag, input logic neg);
      logic signed [63:0] e;
      e = $signed({16'b0, mag});
      if (neg) begin
         e = -e;
      end
      return sat32(e);
   endfunction

endpackage

`default_nettype wire

/* design/dpw_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Several dividends share one divisor; the divisor must be nonzero.
module dpw_div #(
   parameter int LANES = 1,
   parameter int DVD_W = 48,
   parameter int DSR_W = 32,
   parameter int TAG_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [LANES-1:0][DVD_W-1:0]     in_dvd,
   input  logic [DSR_W-1:0]                in_dsr,
   input  logic [LANES-1:0]                in_neg,
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_valid,
   output logic [LANES-1:0][DVD_W-1:0]     out_quo,
   output logic [LANES-1:0]                out_neg,
   output logic [TAG_W-1:0]                out_tag
);

   localparam int LAST = DVD_W - 1;

   logic                        vld_ff [DVD_W];
   logic [LANES-1:0][DVD_W-1:0] quo_ff [DVD_W];
   logic [LANES-1:0]            neg_ff [DVD_W];
   logic [TAG_W-1:0]            tag_ff [DVD_W];
   logic [LANES-1:0][DSR_W-1:0] rem_ff [LAST];
   logic [DSR_W-1:0]            dsr_ff [LAST];

   genvar s;
   for (s = 0; s < DVD_W; s++) begin : g_step
      logic                        p_vld;
      logic [LANES-1:0][DVD_W-1:0] p_quo;
      logic [LANES-1:0][DSR_W-1:0] p_rem;
      logic [DSR_W-1:0]            p_dsr;
      logic [LANES-1:0]            p_neg;
      logic [TAG_W-1:0]            p_tag;
      logic [LANES-1:0][DSR_W:0]   trial;
      logic [LANES-1:0]            ge;
      logic [LANES-1:0][DVD_W-1:0] quo_in;

      // The first stage starts from a zero remainder.
      if (s == 0) begin : g_head
         assign p_vld = in_valid;
         assign p_quo = in_dvd;
         assign p_rem = '0;
         assign p_dsr = in_dsr;
         assign p_neg = in_neg;
         assign p_tag = in_tag;
      end else begin : g_body
         assign p_vld = vld_ff[s-1];
         assign p_quo = quo_ff[s-1];
         assign p_rem = rem_ff[s-1];
         assign p_dsr = dsr_ff[s-1];
         assign p_neg = neg_ff[s-1];
         assign p_tag = tag_ff[s-1];
      end

      // Bring down the next dividend bit and shift in the quotient bit.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]  = {p_rem[l], p_quo[l][DVD_W-1]};
            ge[l]     = (trial[l] >= {1'b0, p_dsr});
            quo_in[l] = {p_quo[l][DVD_W-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s] <= quo_in;
            neg_ff[s] <= p_neg;
            tag_ff[s] <= p_tag;
         end
      end

      // The remainder is only kept where a later stage uses it.
      if (s < LAST) begin : g_rem
         logic [LANES-1:0][DSR_W:0]   diff;
         logic [LANES-1:0][DSR_W-1:0] rem_in;

         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               diff[l]   = trial[l] - {1'b0, p_dsr};
               rem_in[l] = ge[l] ? diff[l][DSR_W-1:0] : trial[l][DSR_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               dsr_ff[s] <= p_dsr;
            end
         end
      end
   end

   assign out_valid = vld_ff[LAST];
   assign out_quo   = quo_ff[LAST];
   assign out_neg   = neg_ff[LAST];
   assign out_tag   = tag_ff[LAST];

endmodule

`default_nettype wire

/* design/dpw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// Front end: depth scaling, range check, inverse intrinsic product and
// preparation of the depth / z division.
module dpw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  dpw_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  dpw_pkg::req_type    in_req,
   output logic                out_valid,
   output logic [47:0]         out_dvd,
   output logic [31:0]         out_dsr,
   output logic                out_neg,
   output dpw_pkg::sc_tag_type out_tag
);

   import dpw_pkg::*;

   // Stage 1: request register.
   logic    v1_ff;
   req_type req1_ff;

   // Stage 2: depth in meters.
   logic        v2_ff;
   logic [31:0] depth2_ff;
   logic        frame2_ff;
   load_type    load2_ff;
   logic [11:0] col2_ff;
   logic [11:0] row2_ff;
   logic [47:0] depth_prod;
   load_type    load2_in;

   // Stage 3: intrinsic products.
   logic               v3_ff;
   logic               ok3_ff;
   logic [31:0]        depth3_ff;
   load_type           load3_ff;
   logic signed [44:0] pa3_ff [3];
   logic signed [44:0] pb3_ff [3];
   logic signed [31:0] k23_ff [3];
   logic signed [44:0] pa_in  [3];
   logic signed [44:0] pb_in  [3];
   logic               ok3_in;

   // Stage 4: local ray.
   logic               v4_ff;
   logic               ok4_ff;
   logic               fault4_ff;
   logic [31:0]        depth4_ff;
   load_type           load4_ff;
   logic signed [31:0] loc4_ff [3];
   sat_type            loc_sat [3];
   logic               fault4_in;

   // Stage 5: divider operands.
   logic        v5_ff;
   logic [47:0] dvd5_ff;
   logic [31:0] dsr5_ff;
   logic        neg5_ff;
   sc_tag_type  tag5_ff;
   sc_tag_type  tag5_in;
   logic        locz0;

   // Inverse intrinsic words, written by loads as they pass stage 2.
   logic [31:0] k_ff [K_WORDS];

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage 2 logic: scale raw depth and check the frame.
   always_comb begin
      depth_prod     = 48'(req1_ff.raw_depth) * 48'(cfg.depth_scale);
      load2_in.en    = (req1_ff.action == ACTION_LOAD);
      load2_in.index = req1_ff.coef_index;
      load2_in.value = req1_ff.coef_value;
   end

   // Stage 3 logic: range check and intrinsic products.
   always_comb begin
      ok3_in = !load2_ff.en && frame2_ff
               && (depth2_ff >= {1'b0, cfg.min_depth_m})
               && (depth2_ff <= {1'b0, cfg.max_depth_m});
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = 45'($signed(k_ff[3*i]))   * 45'($signed({1'b0, col2_ff}));
         pb_in[i] = 45'($signed(k_ff[3*i+1])) * 45'($signed({1'b0, row2_ff}));
      end
   end

   // Stage 4 logic: sum and saturate the ray.
   always_comb begin
      fault4_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         loc_sat[i] = sat32(64'(pa3_ff[i]) + 64'(pb3_ff[i]) + 64'(k23_ff[i]));
         fault4_in  = fault4_in | loc_sat[i].sat;
      end
   end

   // Stage 5 logic: a zero z gets a harmless divisor and is flagged.
   always_comb begin
      locz0               = (loc4_ff[2] == 32'sd0);
      tag5_in.flags.ok    = ok4_ff;
      tag5_in.flags.locz0 = locz0;
      tag5_in.flags.fault = fault4_ff;
      tag5_in.load        = load4_ff;
      for (int i = 0; i < 3; i++) begin
         tag5_in.loc[i] = loc4_ff[i];
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff   <= in_req;

         depth2_ff <= depth_prod[47:16];
         frame2_ff <= ({5'b0, req1_ff.col} < COL_LIMIT) && ({5'b0, req1_ff.row} < ROW_LIMIT);
         load2_ff  <= load2_in;
         col2_ff   <= req1_ff.col;
         row2_ff   <= req1_ff.row;

         ok3_ff    <= ok3_in;
         depth3_ff <= depth2_ff;
         load3_ff  <= load2_ff;
         for (int i = 0; i < 3; i++) begin
            pa3_ff[i] <= pa_in[i];
            pb3_ff[i] <= pb_in[i];
            k23_ff[i] <= $signed(k_ff[3*i+2]);
         end

         ok4_ff    <= ok3_ff;
         fault4_ff <= fault4_in;
         depth4_ff <= depth3_ff;
         load4_ff  <= load3_ff;
         for (int i = 0; i < 3; i++) begin
            loc4_ff[i] <= loc_sat[i].val;
         end

         dvd5_ff <= {depth4_ff, 16'b0};
         dsr5_ff <= locz0 ? 32'd1 : mag32(loc4_ff[2]);
         neg5_ff <= loc4_ff[2][31];
         tag5_ff <= tag5_in;
      end
   end

   // Coefficient loads take effect in request order at stage 2.
   always_ff @(posedge clock) begin
      if (en && v2_ff && load2_ff.en) begin
         for (int i = 0; i < K_WORDS; i++) begin
            if (load2_ff.index == 5'(i)) begin
               k_ff[i] <= load2_ff.value;
            end
         end
      end
   end

   assign out_valid = v5_ff;
   assign out_dvd   = dvd5_ff;
   assign out_dsr   = dsr5_ff;
   assign out_neg   = neg5_ff;
   assign out_tag   = tag5_ff;

endmodule

`default_nettype wire

/* design/dpw_pose.sv */
`timescale 1ns / 1ps
`default_nettype none

// Middle section: camera point from the depth ratio, pose transform and
// preparation of the homogeneous divide.
module dpw_pose (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [dpw_pkg::DVD_W-1:0]     in_quo,
   input  logic                          in_neg,
   input  dpw_pkg::sc_tag_type           in_tag,
   output logic                          out_valid,
   output logic [2:0][dpw_pkg::DVD_W-1:0] out_dvd,
   output logic [31:0]                   out_dsr,
   output logic [2:0]                    out_neg,
   output dpw_pkg::wd_tag_type           out_tag
);

   import dpw_pkg::*;

   // Stage c1: signed, saturated scale.
   logic               vc1_ff;
   sc_tag_type         tag_c1_ff;
   logic signed [31:0] scale_c1_ff;
   sat_type            scale_sat;
   sc_tag_type         tag_c1_in;

   // Stage c2: ray times scale.
   logic               vc2_ff;
   flag_type           flags_c2_ff;
   load_type           load_c2_ff;
   logic signed [63:0] prod_c2_ff [3];

   // Stage c3: camera point.
   logic               vc3_ff;
   flag_type           flags_c3_ff;
   load_type           load_c3_ff;
   logic signed [31:0] cam_c3_ff [3];
   sat_type            cam_sat [3];
   flag_type           flags_c3_in;

   // Stage p1: pose products.
   logic               vp1_ff;
   flag_type           flags_p1_ff;
   logic signed [31:0] cam_p1_ff [3];
   logic signed [63:0] pp_p1_ff [4][3];
   logic signed [31:0] pt_p1_ff [4];

   // Stage p2: homogeneous point.
   logic               vp2_ff;
   flag_type           flags_p2_ff;
   logic signed [31:0] cam_p2_ff [3];
   logic signed [31:0] h_p2_ff [4];
   sat_type            h_sat [4];
   flag_type           flags_p2_in;

   // Stage p3: divider operands.
   logic                  vp3_ff;
   logic [2:0][DVD_W-1:0] dvd_p3_ff;
   logic [31:0]           dsr_p3_ff;
   logic [2:0]            neg_p3_ff;
   wd_tag_type            tag_p3_ff;
   wd_tag_type            tag_p3_in;
   logic                  h3zero;

   // Pose words, written by loads as they pass stage c3.
   logic [31:0] pose_ff [POSE_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
         vc3_ff <= 1'b0;
         vp1_ff <= 1'b0;
         vp2_ff <= 1'b0;
         vp3_ff <= 1'b0;
      end else if (en) begin
         vc1_ff <= in_valid;
         vc2_ff <= vc1_ff;
         vc3_ff <= vc2_ff;
         vp1_ff <= vc3_ff;
         vp2_ff <= vp1_ff;
         vp3_ff <= vp2_ff;
      end
   end

   // Apply the sign of the depth ratio.
   always_comb begin
      scale_sat             = div_result(in_quo, in_neg);
      tag_c1_in             = in_tag;
      tag_c1_in.flags.fault = in_tag.flags.fault | scale_sat.sat;
   end

   // Floor to Q16.16 and saturate the camera point.
   always_comb begin
      flags_c3_in = flags_c2_ff;
      for (int i = 0; i < 3; i++) begin
         cam_sat[i]        = sat32(prod_c2_ff[i] >>> 16);
         flags_c3_in.fault = flags_c3_in.fault | cam_sat[i].sat;
      end
   end

   // Sum the floored pose terms and the translation.
   always_comb begin
      flags_p2_in = flags_p1_ff;
      for (int i = 0; i < 4; i++) begin
         h_sat[i] = sat32((pp_p1_ff[i][0] >>> 16) + (pp_p1_ff[i][1] >>> 16)
                          + (pp_p1_ff[i][2] >>> 16) + 64'(pt_p1_ff[i]));
         flags_p2_in.fault = flags_p2_in.fault | h_sat[i].sat;
      end
   end

   // A zero w gets a harmless divisor and is flagged.
   always_comb begin
      h3zero            = (h_p2_ff[3] == 32'sd0);
      tag_p3_in.flags   = flags_p2_ff;
      tag_p3_in.h3zero  = h3zero;
      for (int i = 0; i < 3; i++) begin
         tag_p3_in.cam[i] = cam_p2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_c1_ff   <= tag_c1_in;
         scale_c1_ff <= scale_sat.val;

         flags_c2_ff <= tag_c1_ff.flags;
         load_c2_ff  <= tag_c1_ff.load;
         for (int i = 0; i < 3; i++) begin
            prod_c2_ff[i] <= 64'($signed(tag_c1_ff.loc[i])) * 64'(scale_c1_ff);
         end

         flags_c3_ff <= flags_c3_in;
         load_c3_ff  <= load_c2_ff;
         for (int i = 0; i < 3; i++) begin
            cam_c3_ff[i] <= cam_sat[i].val;
         end

         flags_p1_ff <= flags_c3_ff;
         for (int i = 0; i < 3; i++) begin
            cam_p1_ff[i] <= cam_c3_ff[i];
         end
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp_p1_ff[i][j] <= 64'($signed(pose_ff[4*i+j])) * 64'(cam_c3_ff[j]);
            end
            pt_p1_ff[i] <= $signed(pose_ff[4*i+3]);
         end

         flags_p2_ff <= flags_p2_in;
         for (int i = 0; i < 3; i++) begin
            cam_p2_ff[i] <= cam_p1_ff[i];
         end
         for (int i = 0; i < 4; i++) begin
            h_p2_ff[i] <= h_sat[i].val;
         end

         for (int i = 0; i < 3; i++) begin
            dvd_p3_ff[i] <= {mag32(h_p2_ff[i]), 16'b0};
            neg_p3_ff[i] <= h_p2_ff[i][31] ^ h_p2_ff[3][31];
         end
         dsr_p3_ff <= h3zero ? 32'd1 : mag32(h_p2_ff[3]);
         tag_p3_ff <= tag_p3_in;
      end
   end

   // Pose loads take effect in request order at stage c3.
   always_ff @(posedge clock) begin
      if (en && vc3_ff && load_c3_ff.en) begin
         for (int i = 0; i < POSE_WORDS; i++) begin
            if (load_c3_ff.index == 5'(POSE_BASE + i)) begin
               pose_ff[i] <= load_c3_ff.value;
            end
         end
      end
   end

   assign out_valid = vp3_ff;
   assign out_dvd   = dvd_p3_ff;
   assign out_dsr   = dsr_p3_ff;
   assign out_neg   = neg_p3_ff;
   assign out_tag   = tag_p3_ff;

endmodule

`default_nettype wire

/* design/depth_pixel_to_world_point_core.sv */
// A request passes 5 front stages, 48 scale divider steps, 6 pose stages, 48 world divider
// steps and 1 output register before its response appears.
// Throughput: one request per cycle unless the output stalls; the two one-bit-per-stage dividers set the depth.
// A stalled response holds the whole pipeline and req_ready follows it.
// Reset is synchronous and active high: it clears valid bits and restores the
// configuration registers; the coefficient store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_to_world_point_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dpw_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dpw_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  dpw_pkg::csr_index_type csr_index,
   input  logic [31:0]           csr_wdata
);

   import dpw_pkg::*;

   logic    en;
   cfg_type cfg_ff;

   logic        fr_valid;
   logic [47:0] fr_dvd;
   logic [31:0] fr_dsr;
   logic        fr_neg;
   sc_tag_type  fr_tag;

   logic             sc_valid;
   logic [DVD_W-1:0] sc_quo;
   logic             sc_neg;
   sc_tag_type       sc_tag;

   logic                  ps_valid;
   logic [2:0][DVD_W-1:0] ps_dvd;
   logic [31:0]           ps_dsr;
   logic [2:0]            ps_neg;
   wd_tag_type            ps_tag;

   logic                  wd_valid;
   logic [2:0][DVD_W-1:0] wd_quo;
   logic [2:0]            wd_neg;
   wd_tag_type            wd_tag;

   sat_type world_sat [3];
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // The pipeline advances whenever the output register can take a response.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_scale <= DEPTH_SCALE_RST;
         cfg_ff.min_depth_m <= MIN_DEPTH_RST;
         cfg_ff.max_depth_m <= MAX_DEPTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEPTH_SCALE: begin
               cfg_ff.depth_scale <= csr_wdata;
            end
            CSR_MIN_DEPTH: begin
               cfg_ff.min_depth_m <= csr_wdata[30:0];
            end
            CSR_MAX_DEPTH: begin
               cfg_ff.max_depth_m <= csr_wdata[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   dpw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (fr_valid),
      .out_dvd   (fr_dvd),
      .out_dsr   (fr_dsr),
      .out_neg   (fr_neg),
      .out_tag   (fr_tag)
   );

   // Depth over local z.
   dpw_div #(
      .LANES (1),
      .DVD_W (DVD_W),
      .DSR_W (DSR_W),
      .TAG_W ($bits(sc_tag_type))
   ) u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_dvd    (fr_dvd),
      .in_dsr    (fr_dsr),
      .in_neg    (fr_neg),
      .in_tag    (fr_tag),
      .out_valid (sc_valid),
      .out_quo   (sc_quo),
      .out_neg   (sc_neg),
      .out_tag   (sc_tag)
   );

   dpw_pose u_pose (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid),
      .in_quo    (sc_quo),
      .in_neg    (sc_neg),
      .in_tag    (sc_tag),
      .out_valid (ps_valid),
      .out_dvd   (ps_dvd),
      .out_dsr   (ps_dsr),
      .out_neg   (ps_neg),
      .out_tag   (ps_tag)
   );

   // World x, y and z over w.
   dpw_div #(
      .LANES (3),
      .DVD_W (DVD_W),
      .DSR_W (DSR_W),
      .TAG_W ($bits(wd_tag_type))
   ) u_world_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ps_valid),
      .in_dvd    (ps_dvd),
      .in_dsr    (ps_dsr),
      .in_neg    (ps_neg),
      .in_tag    (ps_tag),
      .out_valid (wd_valid),
      .out_quo   (wd_quo),
      .out_neg   (wd_neg),
      .out_tag   (wd_tag)
   );

   // Assemble the response; rejected pixels and loads give all zeros.
   always_comb begin
      rsp_in = '0;
      for (int i = 0; i < 3; i++) begin
         world_sat[i] = div_result(wd_quo[i], wd_neg[i]);
      end
      if (wd_tag.flags.ok) begin
         if (wd_tag.flags.locz0) begin
            rsp_in.arith_fault = 1'b1;
         end else begin
            rsp_in.cam_x = $signed(wd_tag.cam[0]);
            rsp_in.cam_y = $signed(wd_tag.cam[1]);
            rsp_in.cam_z = $signed(wd_tag.cam[2]);
            if (wd_tag.h3zero) begin
               rsp_in.arith_fault = 1'b1;
            end else begin
               rsp_in.point_valid = 1'b1;
               rsp_in.arith_fault = wd_tag.flags.fault | world_sat[0].sat
                                    | world_sat[1].sat | world_sat[2].sat;
               rsp_in.world_x     = world_sat[0].val;
               rsp_in.world_y     = world_sat[1].val;
               rsp_in.world_z     = world_sat[2].val;
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= wd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `include "depth_pixel_to_world_point_core_assert.svh"

   // A held response blocks new requests.
   `DPW_ASSERT(a_stall_blocks_req, rsp_valid_ff && !rsp_ready, !req_ready, "request taken during stall")
   // A point that is not valid never carries world coordinates.
   `DPW_ASSERT(a_no_world_when_invalid, rsp_valid_ff && !rsp_ff.point_valid, rsp_ff.world_x == 32'sd0 && rsp_ff.world_y == 32'sd0 && rsp_ff.world_z == 32'sd0, "world set on invalid point")
   // Loads and rejected pixels without a fault give a zero camera point.
   `DPW_ASSERT(a_clean_reject_zero, rsp_valid_ff && !rsp_ff.point_valid && !rsp_ff.arith_fault, rsp_ff.cam_x == 32'sd0 && rsp_ff.cam_y == 32'sd0 && rsp_ff.cam_z == 32'sd0, "camera set on rejected request")
   // A taken response with nothing behind it leaves the output empty.
   `DPW_ASSERT_NEXT(a_drain_clears, rsp_valid_ff && rsp_ready && !wd_valid, !rsp_valid_ff, "response repeated")

endmodule

`default_nettype wire
